### rtl/cesd_pkg.sv
// Shared types and constants for the C escape sequence decoder.
// No dependencies; used by c_escape_sequence_decoder.

package cesd_pkg;

    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_A         = 8'h61;
    localparam logic [7:0] CHR_B         = 8'h62;
    localparam logic [7:0] CHR_F         = 8'h66;
    localparam logic [7:0] CHR_N         = 8'h6E;
    localparam logic [7:0] CHR_R         = 8'h72;
    localparam logic [7:0] CHR_T         = 8'h74;
    localparam logic [7:0] CHR_V         = 8'h76;
    localparam logic [7:0] CHR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHR_DIGIT_7   = 8'h37;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;

    localparam int unsigned OCT_DIGITS_MAX = 3;

    // Decoder mode, one-hot.
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'b001,
        MODE_ESC   = 3'b010,
        MODE_OCT   = 3'b100
    } mode_t;

    // One decoded result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_string;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_map_t;

    // Map the byte after a backslash onto its control byte.
    function automatic esc_map_t simple_escape(input logic [7:0] b);
        esc_map_t r;
        r.hit   = 1'b1;
        r.value = b;
        unique case (b)
            CHR_QUOTE:     r.value = CHR_QUOTE;
            CHR_A:         r.value = CTL_BEL;
            CHR_B:         r.value = CTL_BS;
            CHR_F:         r.value = CTL_FF;
            CHR_N:         r.value = CTL_LF;
            CHR_R:         r.value = CTL_CR;
            CHR_T:         r.value = CTL_HT;
            CHR_V:         r.value = CTL_VT;
            CHR_BACKSLASH: r.value = CHR_BACKSLASH;
            default:       r.hit   = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CHR_DIGIT_0) && (b <= CHR_DIGIT_7);
    endfunction

endpackage

### rtl/c_escape_sequence_decoder.sv
// C escape sequence decoder, top level.
// Depends on cesd_pkg for character constants, mode type and result struct.

// Takes an escaped string one byte per beat on the s_ stream (s_tlast marks
// the final byte) and emits the unescaped bytes on the m_ stream, one result
// per beat. Simple escapes (\" \a \b \f \n \r \t \v \\) become one control
// byte, one to three octal digits become their value truncated to 8 bits, an
// unknown escape gives a backslash and the byte, and a lone trailing backslash
// is dropped. Every string closes with a beat that has m_tlast set; when the
// final input byte produces no data, that beat carries m_tuser = 0 and
// m_tdata = 0. An input byte is decoded in the cycle it is accepted and its
// results (none, one or two) land in a four-entry result queue, so the block
// takes a byte every cycle as long as at least two queue entries are free.
// The sustained rate is one input beat per cycle while m_tready stays high and
// no byte yields two results; a byte that does (an unknown escape, or an octal
// run ended by an ordinary byte) needs two beats of the output port.

module c_escape_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // last_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] byte_present
    output logic       m_tlast    // end_of_string
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Decoder state.
    cesd_pkg::mode_t mode_reg, mode_next;
    logic [8:0]      oval_reg, oval_next;
    logic [1:0]      ocnt_reg, ocnt_next;

    // Result queue.
    cesd_pkg::result_t q_reg [QDEPTH];
    logic [QAW-1:0]    head_reg, head_next;
    logic [QAW-1:0]    tail_reg, tail_next;
    logic [QAW:0]      count_reg, count_next;

    // Decode outputs for the beat on s_.
    cesd_pkg::result_t res [2];
    logic [1:0]        nres;

    logic s_fire, m_fire;

    assign s_tready = (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata  = q_reg[head_reg].out_byte;
    assign m_tuser  = q_reg[head_reg].byte_present;
    assign m_tlast  = q_reg[head_reg].end_of_string;

    // Decode one byte: up to two results and the next state.
    always_comb begin
        cesd_pkg::esc_map_t em;
        logic [8:0]         oacc;
        logic [1:0]         ocnt_inc;
        logic [7:0]         b;

        b         = s_tdata;
        em        = cesd_pkg::simple_escape(b);
        oacc      = {oval_reg[5:0], 3'b000} + {6'b0, b[2:0]};
        ocnt_inc  = ocnt_reg + 2'd1;
        mode_next = mode_reg;
        oval_next = oval_reg;
        ocnt_next = ocnt_reg;
        nres      = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        unique case (mode_reg)
            cesd_pkg::MODE_ESC: begin
                if (em.hit) begin
                    mode_next         = cesd_pkg::MODE_PLAIN;
                    res[nres[0]]      = '{out_byte: em.value, byte_present: 1'b1,
                                          end_of_string: 1'b0};
                    nres              = nres + 2'd1;
                end else if (cesd_pkg::is_octal(b)) begin
                    mode_next = cesd_pkg::MODE_OCT;
                    oval_next = {6'b0, b[2:0]};
                    ocnt_next = 2'd1;
                end else begin
                    // Unknown escape: keep the backslash, then the byte.
                    mode_next    = cesd_pkg::MODE_PLAIN;
                    res[0]       = '{out_byte: cesd_pkg::CHR_BACKSLASH,
                                     byte_present: 1'b1, end_of_string: 1'b0};
                    res[1]       = '{out_byte: b, byte_present: 1'b1,
                                     end_of_string: 1'b0};
                    nres         = 2'd2;
                end
            end
            cesd_pkg::MODE_OCT: begin
                if (cesd_pkg::is_octal(b)) begin
                    if (ocnt_inc >= 2'(cesd_pkg::OCT_DIGITS_MAX)) begin
                        res[nres[0]] = '{out_byte: oacc[7:0], byte_present: 1'b1,
                                         end_of_string: 1'b0};
                        nres         = nres + 2'd1;
                        mode_next    = cesd_pkg::MODE_PLAIN;
                        oval_next    = '0;
                        ocnt_next    = '0;
                    end else begin
                        oval_next = oacc;
                        ocnt_next = ocnt_inc;
                    end
                end else begin
                    // Flush the octal value, then handle the byte as plain.
                    res[0]    = '{out_byte: oval_reg[7:0], byte_present: 1'b1,
                                  end_of_string: 1'b0};
                    nres      = 2'd1;
                    oval_next = '0;
                    ocnt_next = '0;
                    if (b == cesd_pkg::CHR_BACKSLASH) begin
                        mode_next = cesd_pkg::MODE_ESC;
                    end else begin
                        mode_next = cesd_pkg::MODE_PLAIN;
                        res[1]    = '{out_byte: b, byte_present: 1'b1,
                                      end_of_string: 1'b0};
                        nres      = 2'd2;
                    end
                end
            end
            default: begin
                // Plain copy; unused codes fall here too.
                if (b == cesd_pkg::CHR_BACKSLASH) begin
                    mode_next = cesd_pkg::MODE_ESC;
                end else begin
                    mode_next = cesd_pkg::MODE_PLAIN;
                    res[0]    = '{out_byte: b, byte_present: 1'b1,
                                  end_of_string: 1'b0};
                    nres      = 2'd1;
                end
            end
        endcase

        if (s_tlast) begin
            // Close the string: flush a pending octal run, mark the final beat.
            if (mode_next == cesd_pkg::MODE_OCT) begin
                res[nres[0]] = '{out_byte: oval_next[7:0], byte_present: 1'b1,
                                 end_of_string: 1'b0};
                nres         = nres + 2'd1;
            end
            if (nres == 2'd0) begin
                res[0] = '0;
                nres   = 2'd1;
            end
            res[~nres[0]].end_of_string = 1'b1;
            mode_next = cesd_pkg::MODE_PLAIN;
            oval_next = '0;
            ocnt_next = '0;
        end
    end

    // Queue pointer and count update.
    always_comb begin
        logic [1:0] npush;
        npush      = s_fire ? nres : 2'd0;
        tail_next  = tail_reg + QAW'(npush);
        head_next  = head_reg + QAW'(m_fire);
        count_next = count_reg + (QAW+1)'(npush) - (QAW+1)'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= cesd_pkg::MODE_PLAIN;
            oval_reg  <= '0;
            ocnt_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (s_fire) begin
                mode_reg <= mode_next;
                oval_reg <= oval_next;
                ocnt_reg <= ocnt_next;
            end
        end
    end

    // Queue payload: write the first result at the tail, the second after it.
    always_ff @(posedge aclk) begin
        if (s_fire && (nres != 2'd0)) begin
            q_reg[tail_reg] <= res[0];
        end
        if (s_fire && (nres == 2'd2)) begin
            q_reg[tail_reg + QAW'(1)] <= res[1];
        end
    end

endmodule

### tb/tb.sv
// Self-checking testbench for c_escape_sequence_decoder: random and directed escaped
// strings go in on the s_ stream, and every m_ beat is checked against a built-in decoder.
// Depends on cesd_pkg and rtl/c_escape_sequence_decoder.sv only.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_TAIL = 16;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;  // [7:0] in_byte
    logic       s_tlast = 1'b0;   // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [7:0] out_byte
    logic       m_tuser;          // [0] byte_present
    logic       m_tlast;          // end_of_string

    c_escape_sequence_decoder uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Raw string bytes waiting for the driver, packed as {last_byte, in_byte}.
    logic [8:0] raw_string_bytes[$];
    // Decoded characters the block still owes us, oldest first.
    cesd_pkg::result_t decoded_due[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic        s_taken = 1'b0;

    // Decoder state mirrored from the block's behavior.
    cesd_pkg::mode_t dec_mode = cesd_pkg::MODE_PLAIN;
    logic [8:0] oct_acc = 9'd0;
    logic [1:0] oct_count = 2'd0;

    // Results produced by the byte being decoded right now (at most two).
    cesd_pkg::result_t step_res[2];
    int         step_n;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void add_result(input logic [7:0] value, input logic present);
        step_res[step_n].out_byte = present ? value : 8'h00;
        step_res[step_n].byte_present = present;
        step_res[step_n].end_of_string = 1'b0;
        step_n++;
    endfunction

    // Plain copy: a backslash opens an escape, anything else goes straight out.
    function automatic void copy_plain(input logic [7:0] b);
        if (b == cesd_pkg::CHR_BACKSLASH) begin
            dec_mode = cesd_pkg::MODE_ESC;
        end else begin
            dec_mode = cesd_pkg::MODE_PLAIN;
            add_result(b, 1'b1);
        end
    endfunction

    // Advance the decoder by one accepted byte and queue the results it owes.
    function automatic void unescape_byte(input logic [7:0] b, input logic last);
        logic [7:0] ctl;
        logic       simple;
        logic       digit;
        step_n = 0;
        simple = 1'b1;
        ctl = b;
        case (b)
            cesd_pkg::CHR_QUOTE:     ctl = cesd_pkg::CHR_QUOTE;
            cesd_pkg::CHR_A:         ctl = cesd_pkg::CTL_BEL;
            cesd_pkg::CHR_B:         ctl = cesd_pkg::CTL_BS;
            cesd_pkg::CHR_F:         ctl = cesd_pkg::CTL_FF;
            cesd_pkg::CHR_N:         ctl = cesd_pkg::CTL_LF;
            cesd_pkg::CHR_R:         ctl = cesd_pkg::CTL_CR;
            cesd_pkg::CHR_T:         ctl = cesd_pkg::CTL_HT;
            cesd_pkg::CHR_V:         ctl = cesd_pkg::CTL_VT;
            cesd_pkg::CHR_BACKSLASH: ctl = cesd_pkg::CHR_BACKSLASH;
            default:                 simple = 1'b0;
        endcase
        digit = (b >= cesd_pkg::CHR_DIGIT_0) && (b <= cesd_pkg::CHR_DIGIT_7);

        case (dec_mode)
            cesd_pkg::MODE_ESC: begin
                if (simple) begin
                    dec_mode = cesd_pkg::MODE_PLAIN;
                    add_result(ctl, 1'b1);
                end else if (digit) begin
                    oct_acc = {6'd0, b[2:0]};
                    oct_count = 2'd1;
                    dec_mode = cesd_pkg::MODE_OCT;
                end else begin
                    // unknown escape: keep the backslash, then the byte itself
                    dec_mode = cesd_pkg::MODE_PLAIN;
                    add_result(cesd_pkg::CHR_BACKSLASH, 1'b1);
                    add_result(b, 1'b1);
                end
            end
            cesd_pkg::MODE_OCT: begin
                if (digit) begin
                    oct_acc = {oct_acc[5:0], 3'b000} + {6'd0, b[2:0]};
                    oct_count = oct_count + 2'd1;
                    if (oct_count == 2'd3) begin
                        // third digit closes the run at once, value cut to a byte
                        add_result(oct_acc[7:0], 1'b1);
                        dec_mode = cesd_pkg::MODE_PLAIN;
                        oct_acc = 9'd0;
                        oct_count = 2'd0;
                    end
                end else begin
                    // a non-digit flushes the run, then counts as a plain byte
                    add_result(oct_acc[7:0], 1'b1);
                    oct_acc = 9'd0;
                    oct_count = 2'd0;
                    copy_plain(b);
                end
            end
            default: copy_plain(b);
        endcase

        if (last) begin
            if (dec_mode == cesd_pkg::MODE_OCT) add_result(oct_acc[7:0], 1'b1);
            // nothing to show (lone trailing backslash): an empty closing beat
            if (step_n == 0) add_result(8'h00, 1'b0);
            step_res[step_n - 1].end_of_string = 1'b1;
            dec_mode = cesd_pkg::MODE_PLAIN;
            oct_acc = 9'd0;
            oct_count = 2'd0;
        end

        for (int i = 0; i < step_n; i++) decoded_due.push_back(step_res[i]);
    endfunction

    // Queue a byte string; the final byte carries last_byte.
    task automatic add_string(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            raw_string_bytes.push_back({i == txt.len() - 1, txt.getc(i)});
            bytes_queued++;
        end
    endtask

    // Mostly well-formed strings with random content; a plain byte may turn out to be
    // a stray backslash and a lone backslash piece gives broken escapes on purpose.
    task automatic add_random_strings(input int unsigned n_bytes);
        logic [7:0] txt[$];
        int unsigned target;
        int unsigned pieces;
        int unsigned ndig;
        logic [7:0] c;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            txt.delete();
            pieces = $urandom_range(1, 6);
            for (int p = 0; p < pieces; p++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: txt.push_back(8'($urandom_range(0, 255)));
                    4, 5: begin
                        txt.push_back(cesd_pkg::CHR_BACKSLASH);
                        case ($urandom_range(0, 8))
                            0: txt.push_back(cesd_pkg::CHR_QUOTE);
                            1: txt.push_back(cesd_pkg::CHR_A);
                            2: txt.push_back(cesd_pkg::CHR_B);
                            3: txt.push_back(cesd_pkg::CHR_F);
                            4: txt.push_back(cesd_pkg::CHR_N);
                            5: txt.push_back(cesd_pkg::CHR_R);
                            6: txt.push_back(cesd_pkg::CHR_T);
                            7: txt.push_back(cesd_pkg::CHR_V);
                            default: txt.push_back(cesd_pkg::CHR_BACKSLASH);
                        endcase
                    end
                    6, 7: begin
                        txt.push_back(cesd_pkg::CHR_BACKSLASH);
                        ndig = $urandom_range(1, 3);
                        for (int d = 0; d < ndig; d++)
                            txt.push_back(8'(cesd_pkg::CHR_DIGIT_0 + $urandom_range(0, 7)));
                    end
                    8: begin
                        txt.push_back(cesd_pkg::CHR_BACKSLASH);
                        do c = 8'($urandom_range(0, 255));
                        while ((c >= cesd_pkg::CHR_DIGIT_0 && c <= cesd_pkg::CHR_DIGIT_7) ||
                               c == cesd_pkg::CHR_QUOTE || c == cesd_pkg::CHR_A ||
                               c == cesd_pkg::CHR_B || c == cesd_pkg::CHR_F ||
                               c == cesd_pkg::CHR_N || c == cesd_pkg::CHR_R ||
                               c == cesd_pkg::CHR_T || c == cesd_pkg::CHR_V ||
                               c == cesd_pkg::CHR_BACKSLASH);
                        txt.push_back(c);
                    end
                    default: txt.push_back(cesd_pkg::CHR_BACKSLASH);
                endcase
            end
            for (int i = 0; i < txt.size(); i++) begin
                raw_string_bytes.push_back({i == txt.size() - 1, txt[i]});
                bytes_queued++;
            end
        end
    endtask

    // Wait until every queued byte went in and every result came out.
    task automatic wait_all_decoded();
        do @(negedge aclk);
        while (bytes_accepted != bytes_queued || decoded_due.size() != 0);
        @(posedge aclk);
    endtask

    // Sender: hold a beat until taken, then offer the next or go idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (raw_string_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                {s_tlast, s_tdata} <= raw_string_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= RX_HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on every input beat, then check every output beat in order.
    always @(posedge aclk) begin
        cesd_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout: %0d results still due", decoded_due.size());
            $display("[c_escape_sequence_decoder] ERROR");
            $finish;
        end else if (aresetn) begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                unescape_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (decoded_due.size() == 0) begin
                    flag_error($sformatf("unexpected beat data %02h user %0b last %0b",
                                         m_tdata, m_tuser, m_tlast));
                end else begin
                    want = decoded_due.pop_front();
                    if (m_tdata !== want.out_byte)
                        flag_error($sformatf("out_byte %02h, want %02h", m_tdata,
                                             want.out_byte));
                    if (m_tuser !== want.byte_present)
                        flag_error($sformatf("byte_present %0b, want %0b", m_tuser,
                                             want.byte_present));
                    if (m_tlast !== want.end_of_string)
                        flag_error($sformatf("end_of_string %0b, want %0b", m_tlast,
                                             want.end_of_string));
                end
            end
        end
    end

    initial begin
        // Directed strings: one simple escape, a three-digit run that overflows a byte
        // and is followed by a digit copied as data, an octal run cut by a new escape
        // (unknown one), a run cut by an ordinary byte, a run closed by end of string,
        // a lone backslash, a trailing backslash after data, and the byte extremes.
        add_string("\\n");
        add_string("\\7770");
        add_string("\\1\\q");
        add_string("\\12x");
        add_string("\\12");
        add_string("\\");
        add_string("a\\");
        raw_string_bytes.push_back({1'b0, 8'h00});
        raw_string_bytes.push_back({1'b1, 8'hFF});
        bytes_queued += 2;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_all_decoded();

        // Sender idles a little, receiver a lot; one long hold-off fills the block
        // up so that s_tready has to drop while bytes keep coming.
        tx_idle_pct = 23;
        rx_idle_pct = 48;
        hold_requests++;
        add_random_strings(250);
        wait_all_decoded();

        tx_idle_pct = 48;
        rx_idle_pct = 23;
        add_random_strings(250);
        wait_all_decoded();

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_strings(250);
        wait_all_decoded();

        // Give a stray late beat time to show up.
        repeat (DRAIN_TAIL) @(posedge aclk);
        @(negedge aclk);
        if (error_count == 0 && decoded_due.size() == 0) begin
            $display("[c_escape_sequence_decoder] OK");
        end else begin
            $display("[c_escape_sequence_decoder] ERROR");
        end
        $finish;
    end

endmodule
